FILE: rtl/rbe_pkg.sv
// Shared types, constants and the control store of the rANS byte encoder.
// No dependencies; imported by rans_byte_encoder, rans_stream_checker and the testbench.
`default_nettype none

package rbe_pkg;

    localparam int unsigned SYMBOL_COUNT_DEFAULT = 256;
    localparam logic [31:0] LOWER_BOUND          = 32'h0080_0000;
    localparam logic [4:0]  SCALE_BITS_RESET     = 5'd14;
    localparam logic [4:0]  SCALE_BITS_MIN       = 5'd1;
    localparam logic [4:0]  SCALE_BITS_MAX       = 5'd16;

    localparam int unsigned SYMBOL_W = 8;
    localparam int unsigned START_W  = 16;
    localparam int unsigned FREQ_W   = 17;
    localparam int unsigned STATE_W  = 32;
    localparam int unsigned IN_DATA_W  = 48;
    localparam int unsigned OUT_DATA_W = 8;

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_ENCODE = 2'd1;
    localparam logic [1:0] FUNC_FLUSH  = 2'd2;

    typedef logic [3:0] uaddr_t;

    localparam uaddr_t UA_IDLE      = 4'd0;
    localparam uaddr_t UA_CHECK     = 4'd1;
    localparam uaddr_t UA_TEST      = 4'd2;
    localparam uaddr_t UA_RENORM    = 4'd3;
    localparam uaddr_t UA_DIV_SETUP = 4'd4;
    localparam uaddr_t UA_DIV_STEP  = 4'd5;
    localparam uaddr_t UA_COMBINE   = 4'd6;
    localparam uaddr_t UA_ERROR     = 4'd7;
    localparam uaddr_t UA_FLUSH0    = 4'd8;
    localparam uaddr_t UA_FLUSH1    = 4'd9;
    localparam uaddr_t UA_FLUSH2    = 4'd10;
    localparam uaddr_t UA_FLUSH3    = 4'd11;

    typedef enum logic [1:0] {
        BYTE_ZERO,
        BYTE_LOW,
        BYTE_HIGH
    } byte_sel_t;

    typedef enum logic [1:0] {
        LAST_NO,
        LAST_YES,
        LAST_RENORM
    } last_sel_t;

    typedef enum logic [2:0] {
        ST_HOLD,
        ST_SHR8,
        ST_SHL8,
        ST_RESET,
        ST_COMBINE
    } state_op_t;

    typedef enum logic [1:0] {
        DIV_NONE,
        DIV_SETUP,
        DIV_STEP
    } div_op_t;

    typedef enum logic [2:0] {
        J_NEXT,
        J_ALWAYS,
        J_DISPATCH,
        J_IF_BAD,
        J_IF_NOT_GE,
        J_IF_RENORM_MORE,
        J_IF_DIV_MORE
    } jump_t;

    typedef struct packed {
        logic      accept;
        logic      emit;
        byte_sel_t byte_sel;
        last_sel_t last_sel;
        logic      err;
        state_op_t state_op;
        div_op_t   div_op;
        logic      n_inc;
        jump_t     jump;
        uaddr_t    target;
    } ctrl_t;

    // Control store: one word per step of the encoder program.
    function automatic ctrl_t ucode(input uaddr_t addr);
        ctrl_t cw;
        cw          = '0;
        cw.byte_sel = BYTE_ZERO;
        cw.last_sel = LAST_NO;
        cw.state_op = ST_HOLD;
        cw.div_op   = DIV_NONE;
        cw.jump     = J_NEXT;
        cw.target   = UA_IDLE;
        case (addr)
            UA_IDLE: begin
                cw.accept = 1'b1;
                cw.jump   = J_DISPATCH;
            end
            UA_CHECK: begin
                cw.jump   = J_IF_BAD;
                cw.target = UA_ERROR;
            end
            UA_TEST: begin
                cw.jump   = J_IF_NOT_GE;
                cw.target = UA_DIV_SETUP;
            end
            UA_RENORM: begin
                cw.emit     = 1'b1;
                cw.byte_sel = BYTE_LOW;
                cw.last_sel = LAST_RENORM;
                cw.state_op = ST_SHR8;
                cw.n_inc    = 1'b1;
                cw.jump     = J_IF_RENORM_MORE;
                cw.target   = UA_RENORM;
            end
            UA_DIV_SETUP: begin
                cw.div_op = DIV_SETUP;
            end
            UA_DIV_STEP: begin
                cw.div_op = DIV_STEP;
                cw.jump   = J_IF_DIV_MORE;
                cw.target = UA_DIV_STEP;
            end
            UA_COMBINE: begin
                cw.state_op = ST_COMBINE;
                cw.jump     = J_ALWAYS;
            end
            UA_ERROR: begin
                cw.emit     = 1'b1;
                cw.last_sel = LAST_YES;
                cw.err      = 1'b1;
                cw.jump     = J_ALWAYS;
            end
            UA_FLUSH0, UA_FLUSH1, UA_FLUSH2: begin
                cw.emit     = 1'b1;
                cw.byte_sel = BYTE_HIGH;
                cw.state_op = ST_SHL8;
            end
            UA_FLUSH3: begin
                cw.emit     = 1'b1;
                cw.byte_sel = BYTE_HIGH;
                cw.last_sel = LAST_YES;
                cw.state_op = ST_RESET;
                cw.jump     = J_ALWAYS;
            end
            default: begin
                cw.jump = J_ALWAYS;
            end
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rans_byte_encoder.sv
// Top level of the byte-wise rANS encoder: symbol table, coder state,
// microcoded sequencer and output register. Depends on rbe_pkg.
//
// Usage: items arrive on the s_ stream. s_tuser selects the function
// (load a table entry, encode a symbol, flush the state); s_tdata carries
// the symbol, its cumulative start and its frequency. Result items leave
// on the m_ stream: m_tdata is an emitted byte of the reversed output
// stream, m_tlast marks the last result caused by an input item, and
// m_tuser flags an encode of a symbol with zero frequency (or outside the
// table). The scale is written through cfg_wr_en/cfg_wr_data while idle.
// Throughput: one item at a time. An encode other than of a zero-frequency
// symbol runs its renormalization bytes and then a restoring divider that
// makes one quotient bit per cycle and so sets the encode time.
// Reset clears the sequencer, empties the output register, sets the scale
// to 14 and the coder state to 2^23; the symbol table keeps no reset value
// and an entry must be loaded before it is used. When the receiver stalls,
// the result waits in the output register and the program holds at its
// next emitting step; computing steps keep running meanwhile.
`default_nettype none

module rans_byte_encoder
    import rbe_pkg::*;
#(
    parameter int unsigned SYMBOL_COUNT = SYMBOL_COUNT_DEFAULT
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [4:0]            cfg_wr_data,   // scale_bits
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // [7:0] symbol, [23:8] start_value, [40:24] frequency, [47:41] zero
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    input  wire logic [1:0]            s_tuser,       // [1:0] func
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,       // [7:0] out_byte
    output logic                       m_tlast,       // last
    output logic                       m_tuser        // [0] error
);

    localparam int unsigned IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int unsigned ENTRY_W = START_W + FREQ_W;

    // Symbol table memory: {freq, start} per entry.
    logic [ENTRY_W-1:0] table_mem [SYMBOL_COUNT];
    logic [ENTRY_W-1:0] rd_reg;

    // Control and datapath registers.
    uaddr_t             pc_reg, pc_next;
    logic [4:0]         scale_bits_reg, scale_bits_next;
    logic [STATE_W-1:0] state_reg, state_next;
    logic [STATE_W-1:0] lo_reg, lo_next;
    logic [FREQ_W-1:0]  rem_reg, rem_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [1:0]         n_reg, n_next;
    logic               sym_ok_reg, sym_ok_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [7:0]         m_tdata_reg, m_tdata_next;
    logic               m_tlast_reg, m_tlast_next;
    logic               m_tuser_reg, m_tuser_next;

    ctrl_t                cw;
    logic [1:0]           func;
    logic [IDX_W+7:0]     sym_wide;
    logic [IDX_W-1:0]     sym_idx;
    logic                 sym_in_range;
    logic                 in_accept;
    logic [FREQ_W-1:0]    freq;
    logic [START_W-1:0]   start;
    logic [4:0]           pb;
    logic [4:0]           k;
    logic                 ge;
    logic                 ge8;
    logic                 last_rn;
    logic                 out_free;
    logic                 stall;
    logic                 take;
    logic [FREQ_W:0]      trial;
    logic                 q_bit;
    logic [5:0]           lo_shift;

    assign func         = s_tuser;
    assign sym_wide     = {{IDX_W{1'b0}}, s_tdata[7:0]};
    assign sym_idx      = sym_wide[IDX_W-1:0];
    assign sym_in_range = sym_wide < (IDX_W + 8)'(SYMBOL_COUNT);
    assign cw           = ucode(pc_reg);
    assign s_tready     = cw.accept;
    assign in_accept    = s_tvalid && s_tready;

    assign start = rd_reg[START_W-1:0];
    assign freq  = rd_reg[ENTRY_W-1:START_W];

    // Scale clamped to its legal range; k is the bound's power of two.
    always_comb begin
        if (scale_bits_reg < SCALE_BITS_MIN) begin
            pb = SCALE_BITS_MIN;
        end else if (scale_bits_reg > SCALE_BITS_MAX) begin
            pb = SCALE_BITS_MAX;
        end else begin
            pb = scale_bits_reg;
        end
    end
    assign k = 5'd31 - pb;

    // state >= freq * 2^k is the same as (state >> k) >= freq, exactly.
    assign ge      = (state_reg >> k) >= {{(STATE_W-FREQ_W){1'b0}}, freq};
    assign ge8     = ((state_reg >> 8) >> k) >= {{(STATE_W-FREQ_W){1'b0}}, freq};
    assign last_rn = (n_reg == 2'd3) || !ge8;

    assign out_free = !m_tvalid_reg || m_tready;
    assign stall    = (cw.emit && !out_free) || (cw.accept && !s_tvalid);

    // One restoring division step.
    assign trial = {rem_reg, lo_reg[STATE_W-1]};
    assign q_bit = trial >= {1'b0, freq};
    assign lo_shift = 6'd32 - {1'b0, k};

    always_comb begin
        case (cw.jump)
            J_ALWAYS:         take = 1'b1;
            J_IF_BAD:         take = !sym_ok_reg || (freq == '0);
            J_IF_NOT_GE:      take = !ge;
            J_IF_RENORM_MORE: take = !last_rn;
            J_IF_DIV_MORE:    take = cnt_reg != 5'd1;
            default:          take = 1'b0;
        endcase
    end

    always_comb begin
        pc_next         = pc_reg;
        scale_bits_next = scale_bits_reg;
        state_next      = state_reg;
        lo_next         = lo_reg;
        rem_next        = rem_reg;
        cnt_next        = cnt_reg;
        n_next          = n_reg;
        sym_ok_next     = sym_ok_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tlast_next    = m_tlast_reg;
        m_tuser_next    = m_tuser_reg;

        if (cfg_wr_en) begin
            scale_bits_next = cfg_wr_data;
        end

        if (!stall) begin
            // Sequencing.
            if (cw.jump == J_DISPATCH) begin
                case (func)
                    FUNC_ENCODE: pc_next = UA_CHECK;
                    FUNC_FLUSH:  pc_next = UA_FLUSH0;
                    default:     pc_next = UA_IDLE;
                endcase
            end else if (take) begin
                pc_next = cw.target;
            end else begin
                pc_next = pc_reg + 4'd1;
            end

            if (cw.accept) begin
                sym_ok_next = sym_in_range;
                n_next      = 2'd0;
            end
            if (cw.n_inc) begin
                n_next = n_reg + 2'd1;
            end

            // Result item into the output register.
            if (cw.emit) begin
                m_tvalid_next = 1'b1;
                m_tuser_next  = cw.err;
                case (cw.byte_sel)
                    BYTE_LOW:  m_tdata_next = state_reg[7:0];
                    BYTE_HIGH: m_tdata_next = state_reg[31:24];
                    default:   m_tdata_next = 8'd0;
                endcase
                case (cw.last_sel)
                    LAST_YES:    m_tlast_next = 1'b1;
                    LAST_RENORM: m_tlast_next = last_rn;
                    default:     m_tlast_next = 1'b0;
                endcase
            end

            case (cw.div_op)
                DIV_SETUP: begin
                    // Top bits of x are already below freq; the rest feed the divider.
                    rem_next = FREQ_W'(state_reg >> k);
                    lo_next  = state_reg << lo_shift;
                    cnt_next = k;
                end
                DIV_STEP: begin
                    rem_next = q_bit ? FREQ_W'(trial - {1'b0, freq}) : trial[FREQ_W-1:0];
                    lo_next  = {lo_reg[STATE_W-2:0], q_bit};
                    cnt_next = cnt_reg - 5'd1;
                end
                default: begin
                end
            endcase

            case (cw.state_op)
                ST_SHR8:    state_next = state_reg >> 8;
                ST_SHL8:    state_next = state_reg << 8;
                ST_RESET:   state_next = LOWER_BOUND;
                ST_COMBINE: state_next = (lo_reg << pb)
                                       + {{(STATE_W-FREQ_W){1'b0}}, rem_reg}
                                       + {{(STATE_W-START_W){1'b0}}, start};
                default:    state_next = state_reg;
            endcase
        end
    end

    // Table write on a load, registered read on every accepted item.
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            rd_reg <= table_mem[sym_idx];
            if (func == FUNC_LOAD && sym_in_range) begin
                table_mem[sym_idx] <= {s_tdata[40:24], s_tdata[23:8]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg         <= UA_IDLE;
            scale_bits_reg <= SCALE_BITS_RESET;
            state_reg      <= LOWER_BOUND;
            m_tvalid_reg   <= 1'b0;
        end else begin
            pc_reg         <= pc_next;
            scale_bits_reg <= scale_bits_next;
            state_reg      <= state_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        lo_reg      <= lo_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        n_reg       <= n_next;
        sym_ok_reg  <= sym_ok_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef NO_ASSERTIONS
    // Renormalization must leave the state below the bound before dividing.
    a_div_setup_below_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == UA_DIV_SETUP) |-> !ge)
        else $error("division entered with state at or above the bound");

    // The partial remainder of the restoring divider stays below the divisor.
    a_rem_below_freq: assert property (@(posedge aclk) disable iff (!aresetn)
        (pc_reg == UA_DIV_STEP) |-> (rem_reg < freq))
        else $error("divider remainder not below the frequency");

    // An error result is a single zero byte that closes its item.
    a_error_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata == 8'd0)))
        else $error("malformed error result");
`endif

endmodule

`default_nettype wire

FILE: test/rans_stream_checker.sv
`timescale 1ns / 1ps
// Result checker for the rANS byte encoder: follows the item and result streams,
// keeps its own coder state, scale and symbol table, and compares every result.
// Depends on rbe_pkg.
module rans_stream_checker
    import rbe_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [4:0]           cfg_wr_data,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    input  wire logic [IN_DATA_W-1:0] s_tdata,
    input  wire logic [1:0]           s_tuser,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    input  wire logic [7:0]           m_tdata,
    input  wire logic                 m_tlast,
    input  wire logic                 m_tuser,
    output int unsigned               results_due,
    output int unsigned               mismatch_count
);

    typedef struct packed {
        logic [7:0] value;
        logic       last;
        logic       err;
    } coded_byte_t;

    localparam int unsigned REPORT_LIMIT = 10;

    logic [4:0]         scale_reg = SCALE_BITS_RESET;
    logic [STATE_W-1:0] coder_state = LOWER_BOUND;
    logic [START_W-1:0] entry_start [SYMBOL_COUNT_DEFAULT];
    logic [FREQ_W-1:0]  entry_freq  [SYMBOL_COUNT_DEFAULT];
    coded_byte_t        bytes_due [$];
    int unsigned        mismatches = 0;

    // Out-of-range scale settings are clamped into 1..16.
    function automatic logic [4:0] scale_in_use();
        if (scale_reg < SCALE_BITS_MIN) return SCALE_BITS_MIN;
        if (scale_reg > SCALE_BITS_MAX) return SCALE_BITS_MAX;
        return scale_reg;
    endfunction

    task automatic advance_coder(input logic [1:0] func, input logic [7:0] sym,
                                 input logic [START_W-1:0] start,
                                 input logic [FREQ_W-1:0] freq);
        logic [63:0] bound, x, q, r, nx, f;
        logic [4:0]  pb;
        coded_byte_t cb;
        int          n;
        case (func)
            FUNC_LOAD: begin
                entry_start[sym] = start;
                entry_freq[sym]  = freq;
            end
            FUNC_ENCODE: begin
                f = 64'(entry_freq[sym]);
                if (f == 0) begin
                    cb = '{value: 8'h00, last: 1'b1, err: 1'b1};
                    bytes_due.push_back(cb);
                end else begin
                    pb    = scale_in_use();
                    bound = f << (31 - pb);
                    x     = 64'(coder_state);
                    n     = 0;
                    while (x >= bound && n < 4) begin
                        cb.value = x[7:0];
                        cb.err   = 1'b0;
                        x        = x >> 8;
                        n++;
                        // The byte is the last one when the loop stops after it.
                        cb.last  = !(x >= bound && n < 4);
                        bytes_due.push_back(cb);
                    end
                    q  = x / f;
                    r  = x % f;
                    nx = (q << pb) + r + 64'(entry_start[sym]);
                    coder_state = nx[31:0];
                end
            end
            FUNC_FLUSH: begin
                for (n = 3; n >= 0; n--) begin
                    cb.value = coder_state[n*8 +: 8];
                    cb.last  = (n == 0);
                    cb.err   = 1'b0;
                    bytes_due.push_back(cb);
                end
                coder_state = LOWER_BOUND;
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge aclk) begin : watch
        coded_byte_t want;
        if (!aresetn) begin
            scale_reg   = SCALE_BITS_RESET;
            coder_state = LOWER_BOUND;
            bytes_due.delete();
        end else begin
            if (cfg_wr_en)
                scale_reg = cfg_wr_data;
            // Results first: one accepted in this cycle belongs to an older item.
            if (m_tvalid && m_tready) begin
                if (bytes_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result with none expected: byte %02h last %0b error %0b",
                                 $time, m_tdata, m_tlast, m_tuser);
                end else begin
                    want = bytes_due.pop_front();
                    if (m_tdata !== want.value || m_tlast !== want.last ||
                        m_tuser !== want.err) begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT) begin
                            $display("%0t: result mismatch: expected byte %02h last %0b error %0b,",
                                     $time, want.value, want.last, want.err);
                            $display("    got byte %02h last %0b error %0b",
                                     m_tdata, m_tlast, m_tuser);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
                advance_coder(s_tuser, s_tdata[7:0], s_tdata[23:8], s_tdata[40:24]);
        end
        results_due    <= bytes_due.size();
        mismatch_count <= mismatches;
    end

endmodule

FILE: test/rans_byte_encoder_tb.sv
`timescale 1ns / 1ps
// Testbench top for the rANS byte encoder: clock, reset, stimulus, receiver
// stalls, watchdog and verdict. Depends on rbe_pkg, rans_byte_encoder, rans_stream_checker.
module rans_byte_encoder_tb;
    import rbe_pkg::*;

    // Items per random phase; each phase runs at its own scale setting.
    localparam int unsigned PHASE_ITEMS    = 50;
    // The slowest encode (scale 1) runs the longest division; this many quiet
    // cycles after the last result are taken to mean that the block is idle.
    localparam int unsigned SETTLE_CYCLES  = 64;
    // Cycles without any accepted item before the run is declared hung.
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    // The function code that the block must ignore.
    localparam logic [1:0]  FUNC_UNUSED    = 2'd3;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [4:0]           cfg_wr_data;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [7:0]           m_tdata;
    logic                 m_tlast;
    logic                 m_tuser;

    int unsigned results_due;
    int unsigned mismatch_count;
    int unsigned quiet_cycles  = 0;
    int unsigned scale_now     = SCALE_BITS_RESET;
    bit          steady_sender = 1'b0;
    bit          sym_loaded [256];
    logic [7:0]  loaded_syms [$];

    rans_byte_encoder #(
        .SYMBOL_COUNT(SYMBOL_COUNT_DEFAULT)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

    rans_stream_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tlast       (m_tlast),
        .m_tuser       (m_tuser),
        .results_due   (results_due),
        .mismatch_count(mismatch_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Idle lengths: mostly none or a few cycles, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) return 0;
        if (pick < 80) return $urandom_range(1, 3);
        if (pick < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Presents one item after a random gap and returns at the edge where it
    // is accepted. The valid stays high so that a following item with no gap
    // goes out back to back.
    task automatic send_item(input logic [1:0] func, input logic [7:0] sym,
                             input logic [15:0] start, input logic [16:0] freq);
        int unsigned gap;
        gap = steady_sender ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {7'b0, freq, start, sym};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stops sending and waits until every expected result has come and the
    // block has had time to finish any item that produces no result.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Writes the scale register while the block is idle. The stimulus keeps
    // track of the clamped scale so that it can build tables that fit it.
    task automatic set_scale(input logic [4:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        if (value < SCALE_BITS_MIN)
            scale_now = SCALE_BITS_MIN;
        else if (value > SCALE_BITS_MAX)
            scale_now = SCALE_BITS_MAX;
        else
            scale_now = value;
    endtask

    // Loads a table entry and remembers it, since only loaded symbols may be encoded.
    task automatic load_entry(input logic [7:0] sym, input logic [15:0] start,
                              input logic [16:0] freq);
        send_item(FUNC_LOAD, sym, start, freq);
        if (!sym_loaded[sym]) begin
            sym_loaded[sym] = 1'b1;
            loaded_syms.push_back(sym);
        end
    endtask

    // Most entries are well formed for the current scale (start plus freq
    // within 2^scale), with small frequencies favored so that renormalization
    // is frequent. A few have zero frequency or arbitrary values beyond the scale.
    task automatic load_random();
        logic [7:0]  sym;
        int unsigned span, freq, start, pick;
        sym  = 8'($urandom_range(0, 255));
        span = 1 << scale_now;
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            freq  = 0;
            start = $urandom_range(0, span - 1);
        end else if (pick == 1) begin
            freq  = $urandom_range(0, 17'h1ffff);
            start = $urandom_range(0, 16'hffff);
        end else begin
            freq  = (pick < 10) ? $urandom_range(1, (span >> 4) + 1)
                                : $urandom_range(1, span);
            start = $urandom_range(0, span - freq);
        end
        load_entry(sym, 16'(start), 17'(freq));
    endtask

    // Encodes a symbol that has been loaded. The start and frequency fields
    // are unused on an encode, so they carry random bits.
    task automatic encode_random();
        logic [7:0] sym;
        sym = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
        send_item(FUNC_ENCODE, sym, 16'($urandom), 17'($urandom));
    endtask

    // One phase: set the scale, build a small table for it, then mostly
    // encode with the odd reload, flush, drain pause and ignored item mixed in.
    task automatic run_phase(input logic [4:0] value);
        int unsigned done_items, pick, k;
        set_scale(value);
        for (k = 0; k < 6; k++)
            load_random();
        done_items = 6;
        while (done_items < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                // Ignored items do not count toward the phase.
                send_item(FUNC_UNUSED, 8'($urandom), 16'($urandom), 17'($urandom));
            end else begin
                if (pick < 11)
                    load_random();
                else if (pick < 16)
                    send_item(FUNC_FLUSH, 8'($urandom), 16'($urandom), 17'($urandom));
                else if (pick < 18) begin
                    // Let the block drain completely before carrying on.
                    wait_idle();
                    encode_random();
                end else
                    encode_random();
                done_items++;
            end
        end
    endtask

    // Receiver: bursts of readiness, mostly short, sometimes a long stretch
    // with no stalls, separated by stalls of random length.
    initial begin
        int unsigned burst, stall;
        m_tready <= 1'b0;
        forever begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(1, 8);
            m_tready <= 1'b1;
            repeat (burst) @(posedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // Watchdog: any accepted item on either stream restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tuser     <= FUNC_LOAD;
        s_tdata     <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset scale of 14. An unused function code
        // with every field set to all ones must be ignored.
        send_item(FUNC_UNUSED, 8'hff, 16'hffff, 17'h1ffff);
        // Table extremes: smallest frequency, largest start and frequency,
        // zero frequency, a frequency far beyond the scale, and a whole-scale one.
        load_entry(8'd0, 16'd0, 17'd1);
        load_entry(8'd255, 16'hffff, 17'd65536);
        load_entry(8'd1, 16'd0, 17'd0);
        load_entry(8'd2, 16'h1234, 17'h1ffff);
        load_entry(8'd3, 16'd100, 17'd16384);
        // Zero frequency gives a single error result and leaves the state alone.
        send_item(FUNC_ENCODE, 8'd1, 16'd0, 17'd0);
        // From the reset state a frequency of one renormalizes by one byte.
        send_item(FUNC_ENCODE, 8'd0, 16'd0, 17'd0);
        // The whole-scale symbol needs no renormalization and gives no result.
        send_item(FUNC_ENCODE, 8'd3, 16'd0, 17'd0);
        send_item(FUNC_ENCODE, 8'd255, 16'd0, 17'd0);
        send_item(FUNC_ENCODE, 8'd2, 16'd0, 17'd0);
        // Repeated rare symbols push the state up so renormalization takes
        // more than one byte.
        send_item(FUNC_ENCODE, 8'd0, 16'd0, 17'd0);
        send_item(FUNC_ENCODE, 8'd0, 16'd0, 17'd0);
        send_item(FUNC_ENCODE, 8'd0, 16'd0, 17'd0);
        // A flush, then a second flush of the freshly reset state.
        send_item(FUNC_FLUSH, 8'd0, 16'd0, 17'd0);
        send_item(FUNC_FLUSH, 8'hff, 16'hffff, 17'h1ffff);
        send_item(FUNC_ENCODE, 8'd255, 16'd0, 17'd0);

        // Random phases through the scale extremes, the out-of-range settings
        // that clamp, and a few ordinary ones; some phases send back to back.
        run_phase(5'd1);
        run_phase(5'd16);
        steady_sender = 1'b1;
        run_phase(5'd0);
        steady_sender = 1'b0;
        run_phase(5'd31);
        run_phase(5'($urandom_range(2, 15)));
        steady_sender = 1'b1;
        run_phase(5'd8);
        steady_sender = 1'b0;
        run_phase(5'd12);
        run_phase(SCALE_BITS_RESET);

        // Drain, then give the block time to show any stray result.
        wait_idle();
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: rans_byte_encoder.f
rtl/rbe_pkg.sv
rtl/rans_byte_encoder.sv
test/rans_stream_checker.sv
test/rans_byte_encoder_tb.sv
